>>> sv/rbb_pkg.sv
// package for the row box blur: sizes, config and status types, latching functions
// no dependencies; used by every other file of the block
package rbb_pkg;

    localparam int MAX_WINDOW = 127;
    localparam int MAX_ROW    = 4096;

    // fixed field widths
    localparam int PIX_W  = 8;
    localparam int WS_W   = 7;
    localparam int RW_W   = 13;
    localparam int DATA_W = 32;

    // derived widths
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int SIZE_W = $clog2(MAX_WINDOW + 1);
    localparam int HALF_W = $clog2(MAX_WINDOW / 2 + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * ((1 << PIX_W) - 1) + 1);
    localparam int COL_W  = $clog2(MAX_ROW);
    localparam int LEN_W  = $clog2(MAX_ROW + 1);
    localparam int DCNT_W = $clog2(PIX_W);
    localparam int DSH_W  = SIZE_W + PIX_W - 1;

    // register map
    localparam int REG_COUNT = 2;
    localparam int ADDR_W    = $clog2(REG_COUNT * 4);

    typedef enum logic [ADDR_W-3:0] {
        REG_WINDOW_SIZE,
        REG_ROW_WIDTH
    } t_reg_idx;

    typedef struct packed {
        logic [WS_W-1:0] window_size;
        logic [RW_W-1:0] row_width;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // row width as used for a row: zero becomes one, clamp to the largest row
    function automatic logic [LEN_W-1:0] latch_width(input logic [RW_W-1:0] rw);
        logic [LEN_W-1:0] w;
        if (rw == '0) begin
            w = LEN_W'(1);
        end else if (32'(rw) > MAX_ROW) begin
            w = LEN_W'(MAX_ROW);
        end else begin
            w = LEN_W'(rw);
        end
        return w;
    endfunction

    // odd window size, capped, and below the row width except on a one-pixel row
    function automatic logic [SIZE_W-1:0] latch_size(input logic [WS_W-1:0] ws,
                                                     input logic [LEN_W-1:0] w);
        logic [31:0] s;
        logic [31:0] ww;
        logic [31:0] cap;
        s   = 32'(ws);
        ww  = 32'(w);
        cap = 32'((MAX_WINDOW - 1) | 1);
        if (s == 32'd0) begin
            s = 32'd1;
        end
        if (!s[0]) begin
            s = s - 32'd1;
        end
        if (s > cap) begin
            s = cap;
        end
        if (s >= ww) begin
            s = (ww >= 32'd2) ? ((ww >> 1) << 1) - 32'd1 : 32'd1;
        end
        return SIZE_W'(s);
    endfunction

endpackage

>>> sv/rbb_if.sv
// stream interfaces for pixels in and averaged pixels out
// depends on rbb_pkg for the field widths
interface rbb_in_if;
    logic                      valid;
    logic                      ready;
    logic [rbb_pkg::PIX_W-1:0] in_pixel;

    modport source (output valid, output in_pixel, input ready);
    modport sink   (input valid, input in_pixel, output ready);
endinterface

interface rbb_out_if;
    logic                      valid;
    logic                      ready;
    logic [rbb_pkg::PIX_W-1:0] out_pixel;
    logic                      run_last;
    logic                      row_end;

    modport source (output valid, output out_pixel, output run_last, output row_end,
                    input ready);
    modport sink   (input valid, input out_pixel, input run_last, input row_end,
                    output ready);
endinterface

>>> sv/rbb_cfg.sv
// apb register file: window size and row width
// depends on rbb_pkg
module rbb_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rbb_pkg::ADDR_W-1:0]   paddr,
    input  logic [rbb_pkg::DATA_W-1:0]   pwdata,
    output logic [rbb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output rbb_pkg::t_cfg                o_cfg
);

    logic [rbb_pkg::WS_W-1:0] r_window_size;
    logic [rbb_pkg::RW_W-1:0] r_row_width;
    rbb_pkg::t_reg_idx        reg_idx;
    logic                     wr_en;

    assign reg_idx = rbb_pkg::t_reg_idx'(paddr[rbb_pkg::ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= rbb_pkg::WS_W'(1);
            r_row_width   <= rbb_pkg::RW_W'(640);
        end else if (wr_en) begin
            unique case (reg_idx)
                rbb_pkg::REG_WINDOW_SIZE: r_window_size <= pwdata[rbb_pkg::WS_W-1:0];
                rbb_pkg::REG_ROW_WIDTH:   r_row_width   <= pwdata[rbb_pkg::RW_W-1:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            rbb_pkg::REG_WINDOW_SIZE: prdata = rbb_pkg::DATA_W'(r_window_size);
            rbb_pkg::REG_ROW_WIDTH:   prdata = rbb_pkg::DATA_W'(r_row_width);
        endcase
    end

    assign o_cfg.window_size = r_window_size;
    assign o_cfg.row_width   = r_row_width;

endmodule

>>> sv/rbb_store.sv
// ring of recent row pixels, one write and one registered read per cycle
// depends on rbb_pkg; a read and write of the same entry returns the old pixel
module rbb_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rbb_pkg::IDX_W-1:0]  i_waddr,
    input  logic [rbb_pkg::PIX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [rbb_pkg::IDX_W-1:0]  i_raddr,
    output logic [rbb_pkg::PIX_W-1:0]  o_rdata
);

    logic [rbb_pkg::PIX_W-1:0] r_mem [rbb_pkg::MAX_WINDOW];
    logic [rbb_pkg::PIX_W-1:0] r_rdata;

    // read-first port: the pixel leaving the window is read before it is overwritten
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rbb_div.sv
// restoring divider: window sum by window size, one quotient bit per cycle
// depends on rbb_pkg; the quotient always fits a pixel since the sum is below 256 times the size
module rbb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbb_pkg::SUM_W-1:0]  i_dividend,
    input  logic [rbb_pkg::SIZE_W-1:0] i_divisor,
    output rbb_pkg::t_div_stat         o_stat,
    output logic [rbb_pkg::PIX_W-1:0]  o_quot
);

    logic [rbb_pkg::SUM_W-1:0]  r_rem,  n_rem;
    logic [rbb_pkg::DSH_W-1:0]  r_dsh,  n_dsh;
    logic [rbb_pkg::PIX_W-1:0]  r_quot, n_quot;
    logic [rbb_pkg::DCNT_W-1:0] r_cnt,  n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic                       fits;

    assign fits = 32'(r_rem) >= 32'(r_dsh);

    // next quotient bit from one trial subtract
    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_rem  = i_dividend;
            n_dsh  = rbb_pkg::DSH_W'(i_divisor) << (rbb_pkg::PIX_W - 1);
            n_cnt  = '0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = r_rem - rbb_pkg::SUM_W'(r_dsh);
            end
            n_quot = {r_quot[rbb_pkg::PIX_W-2:0], fits};
            n_dsh  = r_dsh >> 1;
            n_cnt  = r_cnt + rbb_pkg::DCNT_W'(1);
            if (r_cnt == rbb_pkg::DCNT_W'(rbb_pkg::PIX_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

>>> sv/row_box_blur_replicated_edges_unit.sv
// top level of the row box blur with replicated edges
// depends on rbb_pkg, rbb_if, rbb_cfg, rbb_store and rbb_div
//
//   channel  | direction | transfer when         | payload
//   ---------+-----------+-----------------------+---------------------------------
//   i_in     | in        | valid && ready        | in_pixel
//   o_out    | out       | valid && ready        | out_pixel, run_last, row_end
//   apb      | in        | psel&&penable&&pwrite | window_size, row_width
//
// a pixel that yields no average passes the ring read and the running-sum update; one that
// yields one also passes the divider and the handoff to the output register. the last pixel
// of a row adds a sum update, a divide and a handoff for each of the half-window flushed averages.
// one pixel is worked on at a time; the next pixel may enter while a result waits
// in the output register, which stalls the divider handoff only.
// synchronous reset clears control state; the ring needs no clearing pass.
module row_box_blur_replicated_edges_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rbb_in_if.sink                      i_in,
    rbb_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbb_pkg::ADDR_W-1:0]  paddr,
    input  logic [rbb_pkg::DATA_W-1:0]  pwdata,
    output logic [rbb_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV
    } t_state;

    rbb_pkg::t_cfg       cfg;
    rbb_pkg::t_div_stat  div_stat;
    logic [rbb_pkg::PIX_W-1:0] div_quot;
    logic [rbb_pkg::PIX_W-1:0] mem_rdata;
    logic                      mem_we;
    logic                      mem_re;
    logic [rbb_pkg::IDX_W-1:0] mem_waddr;
    logic [rbb_pkg::IDX_W-1:0] mem_raddr;
    logic                      div_start;
    logic                      out_free;

    t_state                     r_state,   n_state;
    logic [rbb_pkg::COL_W-1:0]  r_cc,      n_cc;
    logic [rbb_pkg::LEN_W-1:0]  r_len,     n_len;
    logic [rbb_pkg::SIZE_W-1:0] r_eff,     n_eff;
    logic [rbb_pkg::HALF_W-1:0] r_half,    n_half;
    logic [rbb_pkg::HALF_W-1:0] r_k,       n_k;
    logic [rbb_pkg::PIX_W-1:0]  r_first,   n_first;
    logic [rbb_pkg::PIX_W-1:0]  r_pix,     n_pix;
    logic [rbb_pkg::SUM_W-1:0]  r_sum,     n_sum;
    logic [rbb_pkg::IDX_W-1:0]  r_wr_idx,  n_wr_idx;
    logic [rbb_pkg::IDX_W-1:0]  r_rd_idx,  n_rd_idx;
    logic                       r_last,    n_last;
    logic                       r_flush,   n_flush;
    logic                       r_use_mem, n_use_mem;
    logic                       r_prl,     n_prl;
    logic                       r_pre,     n_pre;
    logic                       r_ov,      n_ov;
    logic [rbb_pkg::PIX_W-1:0]  r_opix,    n_opix;
    logic                       r_orl,     n_orl;
    logic                       r_ore,     n_ore;

    function automatic logic [rbb_pkg::IDX_W-1:0] idx_inc(input logic [rbb_pkg::IDX_W-1:0] idx);
        return (idx == rbb_pkg::IDX_W'(rbb_pkg::MAX_WINDOW - 1)) ? '0 : idx + rbb_pkg::IDX_W'(1);
    endfunction

    rbb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rbb_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.in_pixel),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rbb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_eff),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    assign out_free  = !r_ov || o_out.ready;
    assign mem_waddr = r_wr_idx;
    assign mem_raddr = r_rd_idx;

    // sequencer: ring read, sum update, divide, handoff and end-of-row flush
    always_comb begin
        logic                       row_start;
        logic [rbb_pkg::LEN_W-1:0]  cur_len;
        logic [rbb_pkg::SIZE_W-1:0] cur_eff;
        logic [rbb_pkg::PIX_W-1:0]  old;

        n_state   = r_state;
        n_cc      = r_cc;
        n_len     = r_len;
        n_eff     = r_eff;
        n_half    = r_half;
        n_k       = r_k;
        n_first   = r_first;
        n_pix     = r_pix;
        n_sum     = r_sum;
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_last    = r_last;
        n_flush   = r_flush;
        n_use_mem = r_use_mem;
        n_prl     = r_prl;
        n_pre     = r_pre;
        n_ov      = r_ov;
        n_opix    = r_opix;
        n_orl     = r_orl;
        n_ore     = r_ore;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        row_start = (r_cc == '0);
        cur_len   = row_start ? rbb_pkg::latch_width(cfg.row_width) : r_len;
        cur_eff   = row_start ? rbb_pkg::latch_size(cfg.window_size, cur_len) : r_eff;
        old       = r_use_mem ? mem_rdata : r_first;

        // output register drains independently
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // registers latch on the first pixel of a row
                    if (row_start) begin
                        n_len   = cur_len;
                        n_eff   = cur_eff;
                        n_half  = rbb_pkg::HALF_W'((cur_eff - rbb_pkg::SIZE_W'(1)) >> 1);
                        n_first = i_in.in_pixel;
                    end
                    n_pix     = i_in.in_pixel;
                    n_use_mem = !row_start && (32'(r_cc) >= 32'(r_eff));
                    mem_re    = n_use_mem;
                    if (n_use_mem) begin
                        n_rd_idx = idx_inc(r_rd_idx);
                    end
                    mem_we   = 1'b1;
                    n_wr_idx = idx_inc(r_wr_idx);
                    n_last   = (32'(r_cc) + 32'd1) >= 32'(cur_len);
                    n_flush  = 1'b0;
                    n_state  = S_ACC;
                end
            end
            S_ACC: begin
                // running sum: seed with replicated left edge or slide by one
                if (!r_flush && row_start) begin
                    n_sum = rbb_pkg::SUM_W'(r_eff) * rbb_pkg::SUM_W'(r_pix);
                end else begin
                    n_sum = r_sum + rbb_pkg::SUM_W'(r_pix) - rbb_pkg::SUM_W'(old);
                end
                if (r_flush || (32'(r_cc) >= 32'(r_half))) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                    if (r_flush) begin
                        n_pre = (r_k == r_half);
                        n_prl = (r_k == r_half);
                    end else begin
                        n_pre = r_last && (r_half == '0);
                        n_prl = !(r_last && (r_half != '0));
                    end
                end else begin
                    n_cc    = r_cc + rbb_pkg::COL_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done && out_free) begin
                    n_ov   = 1'b1;
                    n_opix = div_quot;
                    n_orl  = r_prl;
                    n_ore  = r_pre;
                    if (r_last && !r_pre) begin
                        // next flushed average: right edge replicated, oldest pixel leaves
                        n_flush   = 1'b1;
                        n_k       = r_flush ? r_k + rbb_pkg::HALF_W'(1) : rbb_pkg::HALF_W'(1);
                        mem_re    = 1'b1;
                        n_rd_idx  = idx_inc(r_rd_idx);
                        n_use_mem = 1'b1;
                        n_state   = S_ACC;
                    end else begin
                        n_state = S_IDLE;
                        if (r_last) begin
                            n_cc     = '0;
                            n_wr_idx = '0;
                            n_rd_idx = '0;
                        end else begin
                            n_cc = r_cc + rbb_pkg::COL_W'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_first <= n_first;
        r_pix   <= n_pix;
        r_opix  <= n_opix;
        r_orl   <= n_orl;
        r_ore   <= n_ore;
        r_prl   <= n_prl;
        r_pre   <= n_pre;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cc      <= '0;
            r_eff     <= rbb_pkg::SIZE_W'(1);
            r_half    <= '0;
            r_k       <= '0;
            r_sum     <= '0;
            r_wr_idx  <= '0;
            r_rd_idx  <= '0;
            r_last    <= 1'b0;
            r_flush   <= 1'b0;
            r_use_mem <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cc      <= n_cc;
            r_eff     <= n_eff;
            r_half    <= n_half;
            r_k       <= n_k;
            r_sum     <= n_sum;
            r_wr_idx  <= n_wr_idx;
            r_rd_idx  <= n_rd_idx;
            r_last    <= n_last;
            r_flush   <= n_flush;
            r_use_mem <= n_use_mem;
            r_ov      <= n_ov;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.out_pixel = r_opix;
    assign o_out.run_last  = r_orl;
    assign o_out.row_end   = r_ore;

endmodule

>>> sv/rbb_checker.sv
// port-level checks for the row box blur, bound to the top level
// depends on rbb_pkg and row_box_blur_replicated_edges_unit
module rbb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rbb_pkg::PIX_W-1:0] i_out_pixel,
    input logic                      i_out_run_last,
    input logic                      i_out_row_end
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its pixel
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel))
        else $error("result pixel changed while stalled");

    // the end of a row also closes the run of its pixel
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_row_end |-> i_out_run_last)
        else $error("row end without run end");

    // one pixel in flight: no input transfer right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a pixel is in flight");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind row_box_blur_replicated_edges_unit rbb_checker u_rbb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_pixel    (o_out.out_pixel),
    .i_out_run_last (o_out.run_last),
    .i_out_row_end  (o_out.row_end)
);

>>> tb/sv/tb.sv
// self-checking testbench for row_box_blur_replicated_edges_unit
// depends on rbb_pkg and rbb_if; drives the pixel stream and apb port, checks the averages
`timescale 1ns / 100ps

module tb;
    import rbb_pkg::*;

    // one expected averaged pixel
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             run_last;
        logic             row_end;
    } t_blur_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic              drv_valid = 1'b0;
    logic [PIX_W-1:0]  drv_pixel = '0;
    logic              mon_ready = 1'b0;
    bit                idle_en = 1'b1;

    // pixels waiting to be sent and averages waiting to come out
    logic [PIX_W-1:0]  pixel_q[$];
    t_blur_res         blurred_q[$];
    int                items_sent = 0;
    int                err_cnt = 0;
    int                gap_left = 0;
    int                stall_left = 0;

    // register copies and the per-row latched view
    logic [WS_W-1:0]   cfg_ws = WS_W'(1);
    logic [RW_W-1:0]   cfg_rw = RW_W'(640);
    logic [PIX_W-1:0]  row_px [0:MAX_ROW-1];
    int                col_pos = 0;
    int                lat_len = 1;
    int                lat_size = 1;
    int                half_w = 0;

    rbb_in_if  in_ch ();
    rbb_out_if out_ch ();

    assign in_ch.valid    = drv_valid;
    assign in_ch.in_pixel = drv_pixel;
    assign out_ch.ready   = mon_ready;

    row_box_blur_replicated_edges_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // row width in use: zero means one, clamp to the longest row
    function automatic int eff_width(input logic [RW_W-1:0] rw);
        int w;
        w = int'(rw);
        if (w == 0) begin
            w = 1;
        end else if (w > MAX_ROW) begin
            w = MAX_ROW;
        end
        return w;
    endfunction

    // odd window, capped, and kept below the row width except on a one-pixel row
    function automatic int eff_size(input logic [WS_W-1:0] ws, input int w);
        int s;
        s = int'(ws);
        if (s == 0) begin
            s = 1;
        end
        if (s % 2 == 0) begin
            s = s - 1;
        end
        if (s > ((MAX_WINDOW - 1) | 1)) begin
            s = (MAX_WINDOW - 1) | 1;
        end
        if (s >= w) begin
            s = (w >= 2) ? (w / 2) * 2 - 1 : 1;
        end
        return s;
    endfunction

    // centred average with the row ends replicated
    function automatic logic [PIX_W-1:0] box_avg(input int centre);
        int acc;
        int idx;
        acc = 0;
        for (int i = centre - half_w; i <= centre + half_w; i++) begin
            idx = (i < 0) ? 0 : ((i > lat_len - 1) ? lat_len - 1 : i);
            acc += int'(row_px[idx]);
        end
        return PIX_W'(acc / lat_size);
    endfunction

    // expected averages caused by one accepted pixel
    function automatic void predict_blur(input logic [PIX_W-1:0] px);
        t_blur_res res;
        bit        last;
        if (col_pos == 0) begin
            lat_len  = eff_width(cfg_rw);
            lat_size = eff_size(cfg_ws, lat_len);
            half_w   = (lat_size - 1) / 2;
        end
        row_px[col_pos] = px;
        last = (col_pos + 1 >= lat_len);
        if (col_pos >= half_w) begin
            res.pix      = box_avg(col_pos - half_w);
            res.run_last = !last || half_w == 0;
            res.row_end  = last && half_w == 0;
            blurred_q    = {blurred_q, res};
        end
        if (last) begin
            // flush of the right-hand half window
            for (int k = 1; k <= half_w; k++) begin
                res.pix      = box_avg(col_pos - half_w + k);
                res.run_last = (k == half_w);
                res.row_end  = (k == half_w);
                blurred_q    = {blurred_q, res};
            end
            col_pos = 0;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // pixel driver with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            gap_left  <= 0;
        end else begin
            if (drv_valid && in_ch.ready) begin
                predict_blur(drv_pixel);
                void'(pixel_q.pop_front());
            end
            if (!(drv_valid && !in_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left  <= gap_left - 1;
                    drv_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    if (idle_en && $urandom_range(0, 7) == 0) begin
                        gap_left  <= $urandom_range(0, 16);
                        drv_valid <= 1'b0;
                    end else begin
                        drv_valid <= 1'b1;
                        drv_pixel <= pixel_q[0];
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls
    always @(posedge i_clk) begin
        t_blur_res want;
        if (!i_rst_n) begin
            mon_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_ch.valid && mon_ready) begin
                if (blurred_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("unexpected average: pix %0d run_last %0b row_end %0b",
                                 out_ch.out_pixel, out_ch.run_last, out_ch.row_end);
                    end
                end else begin
                    want = blurred_q.pop_front();
                    if (out_ch.out_pixel !== want.pix || out_ch.run_last !== want.run_last
                        || out_ch.row_end !== want.row_end) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("average mismatch: exp pix %0d run_last %0b row_end %0b, %s",
                                     want.pix, want.run_last, want.row_end,
                                     $sformatf("got pix %0d run_last %0b row_end %0b",
                                               out_ch.out_pixel, out_ch.run_last,
                                               out_ch.row_end));
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                mon_ready  <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 16);
                mon_ready  <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
            end
        end
    end

    // apb write: setup then access, and keep the register copy in step
    task automatic write_reg(input t_reg_idx idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WINDOW_SIZE) begin
            cfg_ws = WS_W'(value);
        end else begin
            cfg_rw = RW_W'(value);
        end
        @(negedge i_clk);
    endtask

    task automatic add_pixel(input logic [PIX_W-1:0] p);
        pixel_q = {pixel_q, p};
        items_sent++;
    endtask

    // random pixel, leaning towards the extremes
    function automatic logic [PIX_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // block idle: all pixels taken, all averages out, pipeline drained
    task automatic wait_idle();
        while (pixel_q.size() != 0 || blurred_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
    endtask

    initial begin
        int ws;
        int rw;
        int r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of one on a short row
        write_reg(REG_ROW_WIDTH, 4);
        add_pixel(8'd0);
        add_pixel(8'd255);
        add_pixel(8'd128);
        add_pixel(8'd7);
        wait_idle();

        // zero size and zero width: one-pixel rows
        write_reg(REG_WINDOW_SIZE, 0);
        write_reg(REG_ROW_WIDTH, 0);
        add_pixel(8'd255);
        add_pixel(8'd0);
        wait_idle();

        // even size reduced, then clamped below the row width
        write_reg(REG_WINDOW_SIZE, 8);
        write_reg(REG_ROW_WIDTH, 5);
        add_pixel(8'd255);
        add_pixel(8'd255);
        add_pixel(8'd0);
        add_pixel(8'd255);
        add_pixel(8'd0);
        wait_idle();

        // largest size on a two-pixel row
        write_reg(REG_WINDOW_SIZE, 127);
        write_reg(REG_ROW_WIDTH, 2);
        add_pixel(8'd255);
        add_pixel(8'd1);
        wait_idle();

        // registers written mid-row only apply from the next row
        write_reg(REG_WINDOW_SIZE, 3);
        write_reg(REG_ROW_WIDTH, 6);
        add_pixel(8'd10);
        add_pixel(8'd200);
        add_pixel(8'd30);
        wait_idle();
        write_reg(REG_WINDOW_SIZE, 5);
        write_reg(REG_ROW_WIDTH, 4);
        add_pixel(8'd255);
        add_pixel(8'd0);
        add_pixel(8'd90);
        add_pixel(8'd1);
        add_pixel(8'd254);
        add_pixel(8'd0);
        add_pixel(8'd255);
        wait_idle();

        // random settings, mostly short rows
        while (items_sent < 220) begin
            idle_en = ($urandom_range(0, 3) != 0);
            ws = $urandom_range(0, 127);
            r  = $urandom_range(0, 9);
            if (r < 6) begin
                rw = $urandom_range(0, 16);
            end else if (r < 9) begin
                rw = $urandom_range(17, 60);
            end else begin
                rw = $urandom_range(61, 128);
            end
            write_reg(REG_WINDOW_SIZE, ws);
            write_reg(REG_ROW_WIDTH, rw);
            repeat ($urandom_range(1, 2) * eff_width(RW_W'(rw))) add_pixel(rand_pixel());
            wait_idle();
        end

        // widest window on a row just longer than it, no idling
        idle_en = 1'b0;
        write_reg(REG_WINDOW_SIZE, 127);
        write_reg(REG_ROW_WIDTH, 130);
        repeat (130) add_pixel(rand_pixel());
        while (pixel_q.size() != 0 || blurred_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(negedge i_clk);

        if (err_cnt == 0 && blurred_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
